[hdl/mva_pkg.sv]
package mva_pkg;

    localparam int VOICE_COUNT_DEF = 8;
    localparam int MAX_VOICES      = 32;
    localparam int IDX_MAX_W       = 5;
    localparam int NOTE_COUNT      = 128;

    localparam int NOTE_W     = 7;
    localparam int VALUE_W    = 7;
    localparam int CTRL_W     = 7;
    localparam int BEND_W     = 14;
    localparam int OFFSET_W   = 13;
    localparam int PITCH_W    = 16;
    localparam int PITCH_FRAC_W = 8;
    localparam int VOICE_W    = 3;
    localparam int OSC_W      = 3;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - VOICE_W - VALUE_W - PITCH_W - OSC_W;

    localparam int BEND_OFF_MAX = 3072;

    localparam logic [CTRL_W-1:0]  CC_SUSTAIN = 7'd64;
    localparam logic [CTRL_W-1:0]  CC_OSC     = 7'd55;
    localparam logic [NOTE_W:0]    NOTE_A4    = 8'd69;

    localparam logic [VALUE_W-1:0] OSC_T1 = 7'd32;
    localparam logic [VALUE_W-1:0] OSC_T2 = 7'd64;
    localparam logic [VALUE_W-1:0] OSC_T3 = 7'd96;
    localparam logic [VALUE_W-1:0] OSC_T4 = 7'd127;

    typedef enum logic [MODE_W-1:0] {
        MODE_NOTE_ON  = 2'd0,
        MODE_NOTE_OFF = 2'd1,
        MODE_BEND     = 2'd2,
        MODE_CC       = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_START    = 2'd0,
        KIND_GATE_OFF = 2'd1,
        KIND_PITCH    = 2'd2,
        KIND_OSC      = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic [VOICE_W-1:0]        voice;
        logic [VALUE_W-1:0]        gain;
        logic signed [PITCH_W-1:0] pitch;
        logic [OSC_W-1:0]          osc;
        logic                      last;
    } t_result;

    function automatic logic [IDX_MAX_W-1:0] lowest_index(input logic [MAX_VOICES-1:0] vec);
        logic [MAX_VOICES-1:0] low;
        logic [IDX_MAX_W-1:0]  idx;
        low = vec & (~vec + 1'b1);
        idx = '0;
        for (int i = 0; i < MAX_VOICES; i++) begin
            if (low[i]) begin
                idx = idx | IDX_MAX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic signed [PITCH_W-1:0] note_pitch(
        input logic [NOTE_W-1:0]          note,
        input logic signed [OFFSET_W-1:0] offset
    );
        logic signed [NOTE_W:0] semi;
        semi = signed'({1'b0, note}) - signed'(NOTE_A4);
        return signed'({semi, PITCH_FRAC_W'(0)}) + PITCH_W'(offset);
    endfunction

    // floor(value*4/127)
    function automatic logic [OSC_W-1:0] osc_from_value(input logic [VALUE_W-1:0] value);
        logic [OSC_W-1:0] osc;
        if (value >= OSC_T4) begin
            osc = 3'd4;
        end else if (value >= OSC_T3) begin
            osc = 3'd3;
        end else if (value >= OSC_T2) begin
            osc = 3'd2;
        end else if (value >= OSC_T1) begin
            osc = 3'd1;
        end else begin
            osc = 3'd0;
        end
        return osc;
    endfunction

endpackage

[hdl/mva_bend_conv.sv]
module mva_bend_conv (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [mva_pkg::BEND_W-1:0]     i_bend,
    output logic                                  o_done,
    output logic signed [mva_pkg::OFFSET_W-1:0]   o_offset
);

    localparam int SHIFT = 14;
    localparam int DIV   = 2 ** SHIFT - 1;
    localparam int HALF  = (DIV - 1) / 2;
    localparam int SCALE = mva_pkg::BEND_OFF_MAX;
    localparam int NUM_W = 26;
    localparam int SUM_W = NUM_W + 1;
    localparam int Q_W   = mva_pkg::OFFSET_W;

    logic                  r_v1, r_v2, r_v3;
    logic                  r_neg1, r_neg2;
    logic [NUM_W-1:0]      r_x1, r_x2;
    logic [Q_W-1:0]        r_e2;
    logic signed [Q_W-1:0] r_off;

    logic [mva_pkg::BEND_W-1:0] w_mag;
    logic [NUM_W-1:0]           w_x;
    logic [SUM_W-1:0]           w_sum;
    logic [SUM_W-1:0]           w_rem;
    logic [Q_W-1:0]             w_q;

    // |2*bend+1|, scaled and biased for round to nearest
    assign w_mag = {(i_bend[mva_pkg::BEND_W-1] ? ~i_bend[mva_pkg::BEND_W-2:0]
                                               : i_bend[mva_pkg::BEND_W-2:0]), 1'b1};
    assign w_x   = NUM_W'(w_mag) * NUM_W'(SCALE) + NUM_W'(HALF);

    // quotient estimate by 1/(2^14-1), low by at most one
    assign w_sum = SUM_W'(r_x1) + SUM_W'(r_x1 >> SHIFT);
    assign w_rem = SUM_W'(r_x2) - (SUM_W'(r_e2) << SHIFT) + SUM_W'(r_e2);
    assign w_q   = (w_rem >= SUM_W'(DIV)) ? r_e2 + 1'b1 : r_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1   <= w_x;
        r_neg1 <= i_bend[mva_pkg::BEND_W-1];
        r_x2   <= r_x1;
        r_neg2 <= r_neg1;
        r_e2   <= Q_W'(w_sum >> SHIFT);
        r_off  <= r_neg2 ? -signed'(w_q) : signed'(w_q);
    end

    assign o_done   = r_v3;
    assign o_offset = r_off;

endmodule

[hdl/midi_voice_allocator_top.sv]
// MIDI voice allocator: maps note, bend and controller events onto a bank of synth voices.
// Input stream: one item per MIDI event, tuser carries the event mode, tdata the fields.
// Output stream: zero or more update items per event, tlast marks the final one.
// A note on takes the lowest free voice, a note off closes it or marks it held while the
// sustain pedal is down, pedal release closes every held voice, a bend re-sends the pitch
// of every busy voice, controller 55 broadcasts an oscillator select.
// Events are handled one at a time by a sequencer around two memories with registered reads:
// a single-port note to voice map and a voice to note memory with separate read and write addresses.
// A pitch bend runs through the three-stage bend converter, then one memory read per busy voice.
// For a note on, the result passes through the decode and emit states into the output register.
// Reset clears all voices, the pedal, the bend and the map valid bits; no clearing pass.
// A stalled receiver holds the output register; the sequencer waits for it to drain
// before placing the next result and takes no new event until the current one is done.
module midi_voice_allocator_top #(
    parameter int VOICE_COUNT = mva_pkg::VOICE_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mva_pkg::IN_DATA_W-1:0]      i_s_tdata,  // note, value, control, bend
    input  logic [mva_pkg::MODE_W-1:0]         i_s_tuser,  // mode
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mva_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // voice, gain, pitch, osc
    output logic [mva_pkg::KIND_W-1:0]         o_m_tuser,  // kind
    output logic                               o_m_tlast
);

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int NW = mva_pkg::NOTE_W;
    localparam int NOTE_AW = $clog2(mva_pkg::NOTE_COUNT);

    localparam int NOTE_LO  = 0;
    localparam int VALUE_LO = NOTE_LO + mva_pkg::NOTE_W;
    localparam int CTRL_LO  = VALUE_LO + mva_pkg::VALUE_W;
    localparam int BEND_LO  = CTRL_LO + mva_pkg::CTRL_W;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_MAPRD   = 8'b0000_0100,
        S_OFFCHK  = 8'b0000_1000,
        S_BEND    = 8'b0001_0000,
        S_SCAN    = 8'b0010_0000,
        S_RDVOICE = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    mva_pkg::t_mode                       r_mode;
    logic [NW-1:0]                        r_note;
    logic [mva_pkg::VALUE_W-1:0]          r_value;
    logic [mva_pkg::CTRL_W-1:0]           r_control;
    logic signed [mva_pkg::BEND_W-1:0]    r_bend;

    logic [VOICE_COUNT-1:0]               r_busy, n_busy;
    logic [VOICE_COUNT-1:0]               r_held, n_held;
    logic [VOICE_COUNT-1:0]               r_todo, n_todo;
    logic                                 r_pedal, n_pedal;
    logic                                 r_scan_held, n_scan_held;
    logic signed [mva_pkg::OFFSET_W-1:0]  r_bend_off, n_bend_off;
    logic [VW-1:0]                        r_vidx, n_vidx;
    mva_pkg::t_result                     r_res, n_res;
    logic                                 r_more, n_more;

    mva_pkg::t_result                     r_out;
    logic                                 r_out_valid;

    logic [VW-1:0]                        m_map [mva_pkg::NOTE_COUNT];
    logic [mva_pkg::NOTE_COUNT-1:0]       r_map_vld;
    logic [VW-1:0]                        r_map_rd;
    logic                                 r_map_ok;

    logic [NW-1:0]                        m_vnote [VOICE_COUNT];
    logic [NW-1:0]                        r_vnote_rd;

    logic                                 w_map_we;
    logic                                 w_vn_we;
    logic [VW-1:0]                        w_vn_addr;
    logic [VOICE_COUNT-1:0]               w_free_vec;
    logic [VW-1:0]                        w_free_idx;
    logic                                 w_free_any;
    logic [VW-1:0]                        w_todo_idx;
    logic                                 w_todo_any;
    logic [VOICE_COUNT-1:0]               w_todo_rest;
    logic                                 w_out_free;
    logic                                 w_map_hit;
    logic                                 w_conv_start;
    logic                                 w_conv_done;
    logic signed [mva_pkg::OFFSET_W-1:0]  w_conv_offset;

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || i_m_tready;

    assign w_free_vec  = ~r_busy;
    assign w_free_any  = |w_free_vec;
    assign w_free_idx  = VW'(mva_pkg::lowest_index(mva_pkg::MAX_VOICES'(w_free_vec)));
    assign w_todo_any  = |r_todo;
    assign w_todo_idx  = VW'(mva_pkg::lowest_index(mva_pkg::MAX_VOICES'(r_todo)));
    assign w_todo_rest = r_todo & ~(VOICE_COUNT'(1) << w_todo_idx);

    assign w_map_hit = r_map_ok && ((VW + 1)'(r_map_rd) < (VW + 1)'(VOICE_COUNT))
                       && r_busy[r_map_rd] && !r_held[r_map_rd];

    always_comb begin
        unique case (r_state)
            S_MAPRD: w_vn_addr = r_map_rd;
            S_SCAN:  w_vn_addr = w_todo_idx;
            default: w_vn_addr = r_vidx;
        endcase
    end

    mva_bend_conv u_bend_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_conv_start),
        .i_bend   (r_bend),
        .o_done   (w_conv_done),
        .o_offset (w_conv_offset)
    );

    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_held       = r_held;
        n_todo       = r_todo;
        n_pedal      = r_pedal;
        n_scan_held  = r_scan_held;
        n_bend_off   = r_bend_off;
        n_vidx       = r_vidx;
        n_res        = r_res;
        n_more       = r_more;
        w_map_we     = 1'b0;
        w_vn_we      = 1'b0;
        w_conv_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_mode)
                    mva_pkg::MODE_NOTE_ON: begin
                        if (w_free_any) begin
                            w_map_we           = 1'b1;
                            w_vn_we            = 1'b1;
                            n_busy[w_free_idx] = 1'b1;
                            n_held[w_free_idx] = 1'b0;
                            n_res              = '0;
                            n_res.kind         = mva_pkg::KIND_START;
                            n_res.voice        = mva_pkg::VOICE_W'(w_free_idx);
                            n_res.gain         = r_value;
                            n_res.pitch        = mva_pkg::note_pitch(r_note, r_bend_off);
                            n_res.last         = 1'b1;
                            n_more             = 1'b0;
                            n_state            = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    mva_pkg::MODE_NOTE_OFF: begin
                        n_state = S_MAPRD;
                    end
                    mva_pkg::MODE_BEND: begin
                        w_conv_start = 1'b1;
                        n_state      = S_BEND;
                    end
                    mva_pkg::MODE_CC: begin
                        if (r_control == mva_pkg::CC_SUSTAIN) begin
                            if (r_value != '0) begin
                                n_pedal = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_pedal     = 1'b0;
                                n_todo      = r_held;
                                n_scan_held = 1'b1;
                                n_state     = S_SCAN;
                            end
                        end else if (r_control == mva_pkg::CC_OSC) begin
                            n_res      = '0;
                            n_res.kind = mva_pkg::KIND_OSC;
                            n_res.osc  = mva_pkg::osc_from_value(r_value);
                            n_res.last = 1'b1;
                            n_more     = 1'b0;
                            n_state    = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MAPRD: begin
                if (w_map_hit) begin
                    n_vidx  = r_map_rd;
                    n_state = S_OFFCHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OFFCHK: begin
                if (r_vnote_rd == r_note) begin
                    if (r_pedal) begin
                        n_held[r_vidx] = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_busy[r_vidx] = 1'b0;
                        n_res          = '0;
                        n_res.kind     = mva_pkg::KIND_GATE_OFF;
                        n_res.voice    = mva_pkg::VOICE_W'(r_vidx);
                        n_res.last     = 1'b1;
                        n_more         = 1'b0;
                        n_state        = S_EMIT;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BEND: begin
                if (w_conv_done) begin
                    n_bend_off  = w_conv_offset;
                    n_todo      = r_busy;
                    n_scan_held = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_todo_any) begin
                    n_state = S_IDLE;
                end else begin
                    n_todo = w_todo_rest;
                    n_vidx = w_todo_idx;
                    if (r_scan_held) begin
                        n_held[w_todo_idx] = 1'b0;
                        n_busy[w_todo_idx] = 1'b0;
                        n_res              = '0;
                        n_res.kind         = mva_pkg::KIND_GATE_OFF;
                        n_res.voice        = mva_pkg::VOICE_W'(w_todo_idx);
                        n_res.last         = (w_todo_rest == '0);
                        n_more             = 1'b1;
                        n_state            = S_EMIT;
                    end else begin
                        n_state = S_RDVOICE;
                    end
                end
            end
            S_RDVOICE: begin
                n_res       = '0;
                n_res.kind  = mva_pkg::KIND_PITCH;
                n_res.voice = mva_pkg::VOICE_W'(r_vidx);
                n_res.pitch = mva_pkg::note_pitch(r_vnote_rd, r_bend_off);
                n_res.last  = (r_todo == '0);
                n_more      = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = r_more ? S_SCAN : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_held      <= '0;
            r_todo      <= '0;
            r_pedal     <= 1'b0;
            r_scan_held <= 1'b0;
            r_bend_off  <= '0;
            r_more      <= 1'b0;
            r_map_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_held      <= n_held;
            r_todo      <= n_todo;
            r_pedal     <= n_pedal;
            r_scan_held <= n_scan_held;
            r_bend_off  <= n_bend_off;
            r_more      <= n_more;
            if (w_map_we) begin
                r_map_vld[r_note] <= 1'b1;
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_mode    <= mva_pkg::t_mode'(i_s_tuser);
            r_note    <= i_s_tdata[NOTE_LO +: mva_pkg::NOTE_W];
            r_value   <= i_s_tdata[VALUE_LO +: mva_pkg::VALUE_W];
            r_control <= i_s_tdata[CTRL_LO +: mva_pkg::CTRL_W];
            r_bend    <= signed'(i_s_tdata[BEND_LO +: mva_pkg::BEND_W]);
        end
        r_vidx <= n_vidx;
        r_res  <= n_res;
        if (r_state == S_EMIT && w_out_free) begin
            r_out <= r_res;
        end
    end

    // note to voice map
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            m_map[NOTE_AW'(r_note)] <= w_free_idx;
        end
        r_map_rd <= m_map[NOTE_AW'(r_note)];
        r_map_ok <= r_map_vld[r_note];
    end

    // voice to note
    always_ff @(posedge i_clk) begin
        if (w_vn_we) begin
            m_vnote[w_free_idx] <= r_note;
        end
        r_vnote_rd <= m_vnote[w_vn_addr];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {mva_pkg::OUT_PAD_W'(0), r_out.osc, r_out.pitch, r_out.gain,
                         r_out.voice};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;

    a_held_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held & ~r_busy) == '0)
        else $error("held voice that is not busy");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_state == S_DECODE)
        else $error("accepted item not decoded");

    a_release_pedal_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && r_scan_held |-> !r_pedal)
        else $error("release scan with pedal down");

    a_bend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bend_off >= -mva_pkg::BEND_OFF_MAX && r_bend_off <= mva_pkg::BEND_OFF_MAX)
        else $error("bend offset out of range");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && w_out_free |=> o_m_tvalid)
        else $error("result not placed in output register");

endmodule
